// ----- hw/rtl/eht_pkg.sv -----
`timescale 1ns / 1ps
package eht_pkg;

  localparam int MAX_DEPTH   = 8;
  localparam int NUM_BUCKETS = 256;
  localparam int SLOTS       = 2;

  localparam int DIR_AW      = MAX_DEPTH;
  localparam int DIR_ENTRIES = 1 << MAX_DEPTH;
  localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int CNT_W       = BKT_W + 1;
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W       = 32;
  localparam int OFF_W       = 32;
  localparam int STAT_W      = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [OFF_W-1:0] off;
  } slot_t;

  typedef slot_t [SLOTS-1:0] row_t;

  typedef struct packed {
    logic              we;
    logic [DIR_AW-1:0] addr;
    logic [BKT_W-1:0]  data;
  } dir_wr_t;

  typedef struct packed {
    logic             we;
    logic [BKT_W-1:0] addr;
    row_t             row;
  } row_wr_t;

  typedef struct packed {
    logic               we;
    logic [BKT_W-1:0]   addr;
    logic [DEPTH_W-1:0] depth;
  } ld_wr_t;

endpackage

// ----- hw/rtl/eht_dir_ram.sv -----
`timescale 1ns / 1ps
// Directory RAM; entries 0 and 1 read as bucket 0 until first written.
module eht_dir_ram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [eht_pkg::DIR_AW-1:0] rd_addr,
  input  eht_pkg::dir_wr_t           wr,
  output logic [eht_pkg::BKT_W-1:0]  rd_data
);
  import eht_pkg::*;

  logic [BKT_W-1:0]  mem [DIR_ENTRIES];
  logic [BKT_W-1:0]  q_r;
  logic [DIR_AW-1:0] ra_r;
  logic [1:0]        ok_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    q_r  <= mem[rd_addr];
    ra_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= '0;
    end else if (wr.we && ((wr.addr >> 1) == '0)) begin
      ok_r[wr.addr[0]] <= 1'b1;
    end
  end

  assign rd_data = (((ra_r >> 1) == '0) && !ok_r[ra_r[0]]) ? '0 : q_r;

endmodule

// ----- hw/rtl/eht_bkt_ram.sv -----
`timescale 1ns / 1ps
// Bucket rows and local depths; bucket 0 reads empty / depth 0 until written.
// Other buckets are fully written when allocated by a split.
module eht_bkt_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [eht_pkg::BKT_W-1:0]   rd_addr,
  input  eht_pkg::row_wr_t            row_wr,
  input  eht_pkg::ld_wr_t             ld_wr,
  output eht_pkg::row_t               row_data,
  output logic [eht_pkg::DEPTH_W-1:0] ld_data
);
  import eht_pkg::*;

  row_t               row_mem [NUM_BUCKETS];
  logic [DEPTH_W-1:0] ld_mem  [NUM_BUCKETS];
  row_t               row_q_r;
  logic [DEPTH_W-1:0] ld_q_r;
  logic               ra0_r;
  logic               row0_ok_r;
  logic               ld0_ok_r;

  always_ff @(posedge clk) begin
    if (row_wr.we) begin
      row_mem[row_wr.addr] <= row_wr.row;
    end
    if (ld_wr.we) begin
      ld_mem[ld_wr.addr] <= ld_wr.depth;
    end
    row_q_r <= row_mem[rd_addr];
    ld_q_r  <= ld_mem[rd_addr];
    ra0_r   <= (rd_addr == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_ok_r <= 1'b0;
      ld0_ok_r  <= 1'b0;
    end else begin
      if (row_wr.we && row_wr.addr == '0) row0_ok_r <= 1'b1;
      if (ld_wr.we && ld_wr.addr == '0) ld0_ok_r <= 1'b1;
    end
  end

  assign row_data = (ra0_r && !row0_ok_r) ? '0 : row_q_r;
  assign ld_data  = (ra0_r && !ld0_ok_r) ? '0 : ld_q_r;

endmodule

// ----- hw/rtl/extendible_hash_table_core.sv -----
`timescale 1ns / 1ps
// Sequence: a lookup or a plain insert reads the directory (S_DIR), then the
// bucket (S_BKT), checks the row (S_ROW) and registers its result in S_DONE.
// Each bucket split writes both halves (S_SPLA, S_SPLB), sweeps the directory on one
// RAM port (S_SWP), then retries; a doubling first runs its own sweep (S_DBL).
// Throughput: one request at a time; next request taken once result is queued.
// Reset: synchronous, active low; no clearing pass, bucket 0 reads empty and directory
// entries 0/1 read as bucket 0 through flags, other entries are written on use.
module extendible_hash_table_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [eht_pkg::KEY_W-1:0]  in_key,
  input  logic [eht_pkg::OFF_W-1:0]  in_offset,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [eht_pkg::STAT_W-1:0] out_status,
  output logic [eht_pkg::OFF_W-1:0]  out_found_offset
);
  import eht_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIR, S_BKT, S_ROW, S_DBL, S_SPLA, S_SPLB, S_SWP, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic                cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [BKT_W-1:0]    b_r, b_nxt;
  row_t                row_r, row_nxt;
  logic [DEPTH_W-1:0]  ld_r, ld_nxt;
  logic [DEPTH_W-1:0]  gd_r, gd_nxt;
  logic [CNT_W-1:0]    biu_r, biu_nxt;
  logic [DIR_AW:0]     idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [DIR_AW-1:0]   pipe_r, pipe_nxt;
  logic [STAT_W-1:0]   res_st_r, res_st_nxt;
  logic [OFF_W-1:0]    res_off_r, res_off_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_st_r, out_st_nxt;
  logic [OFF_W-1:0]    out_off_r, out_off_nxt;

  // memory ports
  logic [DIR_AW-1:0]   dir_raddr;
  logic [BKT_W-1:0]    dir_rdata;
  dir_wr_t             dir_wr;
  logic [BKT_W-1:0]    bkt_raddr;
  row_t                row_rd;
  logic [DEPTH_W-1:0]  ld_rd;
  row_wr_t             row_wr;
  ld_wr_t              ld_wr;

  eht_dir_ram u_dir (
    .clk(clk), .rst_n(rst_n), .rd_addr(dir_raddr), .wr(dir_wr), .rd_data(dir_rdata)
  );

  eht_bkt_ram u_bkt (
    .clk(clk), .rst_n(rst_n), .rd_addr(bkt_raddr), .row_wr(row_wr), .ld_wr(ld_wr),
    .row_data(row_rd), .ld_data(ld_rd)
  );

  // directory size and the key's directory index
  logic [DIR_AW:0]   dir_size;
  logic [DIR_AW-1:0] dir_idx;
  assign dir_size = (DIR_AW + 1)'(1) << gd_r;
  assign dir_idx  = key_r[DIR_AW-1:0] & (dir_size[DIR_AW-1:0] - DIR_AW'(1));

  // bucket probe: key match and lowest free slot
  logic               hit;
  logic [OFF_W-1:0]   hit_off;
  logic               has_free;
  logic [SLOT_IW-1:0] free_idx;
  row_t               ins_row;

  always_comb begin
    hit      = 1'b0;
    hit_off  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (!hit && row_rd[s].vld && row_rd[s].key == key_r) begin
        hit     = 1'b1;
        hit_off = row_rd[s].off;
      end
      if (!has_free && !row_rd[s].vld) begin
        has_free = 1'b1;
        free_idx = SLOT_IW'(s);
      end
    end
    ins_row = row_rd;
    ins_row[free_idx] = '{vld: 1'b1, key: key_r, off: off_r};
  end

  // split of the held row on bit ld_r: movers pack into the new bucket in order
  row_t             keep_row;
  row_t             move_row;
  logic [SLOT_IW:0] mv_cnt;

  always_comb begin
    keep_row = row_r;
    move_row = '0;
    mv_cnt   = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (row_r[s].vld && row_r[s].key[ld_r]) begin
        keep_row[s].vld = 1'b0;
        move_row[mv_cnt[SLOT_IW-1:0]] = row_r[s];
        mv_cnt = mv_cnt + 1'b1;
      end
    end
  end

  logic sweep_busy;
  logic sweep_end;
  assign sweep_busy = (idx_r < dir_size);
  assign sweep_end  = !sweep_busy && !pend_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    off_nxt       = off_r;
    b_nxt         = b_r;
    row_nxt       = row_r;
    ld_nxt        = ld_r;
    gd_nxt        = gd_r;
    biu_nxt       = biu_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pipe_nxt      = pipe_r;
    res_st_nxt    = res_st_r;
    res_off_nxt   = res_off_r;
    out_st_nxt    = out_st_r;
    out_off_nxt   = out_off_r;
    out_valid_nxt = out_valid_r && out_stall;
    dir_raddr     = dir_idx;
    bkt_raddr     = b_r;
    dir_wr        = '0;
    row_wr        = '0;
    ld_wr         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          key_nxt   = in_key;
          off_nxt   = in_offset;
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        state_nxt = S_BKT;
      end
      S_BKT: begin
        b_nxt     = dir_rdata;
        bkt_raddr = dir_rdata;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        row_nxt     = row_rd;
        ld_nxt      = ld_rd;
        idx_nxt     = '0;
        pend_nxt    = 1'b0;
        res_off_nxt = '0;
        state_nxt   = S_DONE;
        if (hit) begin
          res_st_nxt = (cmd_r == CMD_LOOKUP) ? ST_FOUND : ST_PRESENT;
          if (cmd_r == CMD_LOOKUP) res_off_nxt = hit_off;
        end else if (cmd_r == CMD_LOOKUP) begin
          res_st_nxt = ST_NOT_FOUND;
        end else if (has_free) begin
          row_wr     = '{we: 1'b1, addr: b_r, row: ins_row};
          res_st_nxt = ST_INSERTED;
        end else if (biu_r >= CNT_W'(NUM_BUCKETS)) begin
          res_st_nxt = ST_OVERFLOW;
        end else if (ld_rd >= gd_r) begin
          if (gd_r >= DEPTH_W'(MAX_DEPTH)) begin
            res_st_nxt = ST_OVERFLOW;
          end else begin
            state_nxt = S_DBL;
          end
        end else begin
          state_nxt = S_SPLA;
        end
      end
      S_DBL: begin
        // copy lower half of the directory into the upper half
        dir_raddr = idx_r[DIR_AW-1:0];
        pend_nxt  = sweep_busy;
        if (sweep_busy) begin
          pipe_nxt = idx_r[DIR_AW-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r) begin
          dir_wr = '{we: 1'b1, addr: pipe_r + dir_size[DIR_AW-1:0], data: dir_rdata};
        end
        if (sweep_end) begin
          gd_nxt    = gd_r + 1'b1;
          state_nxt = S_SPLA;
        end
      end
      S_SPLA: begin
        row_wr    = '{we: 1'b1, addr: b_r, row: keep_row};
        ld_wr     = '{we: 1'b1, addr: b_r, depth: ld_r + 1'b1};
        state_nxt = S_SPLB;
      end
      S_SPLB: begin
        row_wr    = '{we: 1'b1, addr: biu_r[BKT_W-1:0], row: move_row};
        ld_wr     = '{we: 1'b1, addr: biu_r[BKT_W-1:0], depth: ld_r + 1'b1};
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = S_SWP;
      end
      S_SWP: begin
        // repoint entries of the old bucket with bit ld set to the new bucket
        dir_raddr = idx_r[DIR_AW-1:0];
        pend_nxt  = sweep_busy;
        if (sweep_busy) begin
          pipe_nxt = idx_r[DIR_AW-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r && dir_rdata == b_r && ((pipe_r >> ld_r) & DIR_AW'(1)) != '0) begin
          dir_wr = '{we: 1'b1, addr: pipe_r, data: biu_r[BKT_W-1:0]};
        end
        if (sweep_end) begin
          biu_nxt   = biu_r + 1'b1;
          state_nxt = S_DIR;   // retry the insert
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_off_nxt   = res_off_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gd_r        <= DEPTH_W'(1);
      biu_r       <= CNT_W'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gd_r        <= gd_nxt;
      biu_r       <= biu_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    off_r     <= off_nxt;
    b_r       <= b_nxt;
    row_r     <= row_nxt;
    ld_r      <= ld_nxt;
    idx_r     <= idx_nxt;
    pipe_r    <= pipe_nxt;
    res_st_r  <= res_st_nxt;
    res_off_r <= res_off_nxt;
    out_st_r  <= out_st_nxt;
    out_off_r <= out_off_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_st_r;
  assign out_found_offset = out_off_r;

  // global depth stays within its limits
  a_gd_range: assert property (@(posedge clk) disable iff (!rst_n)
    gd_r >= DEPTH_W'(1) && gd_r <= DEPTH_W'(MAX_DEPTH))
    else $error("global depth out of range");

  // bucket count never passes the pool size
  a_biu_range: assert property (@(posedge clk) disable iff (!rst_n)
    biu_r >= CNT_W'(1) && biu_r <= CNT_W'(NUM_BUCKETS))
    else $error("bucket count out of range");

  // global depth only grows one step at a time
  a_gd_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && gd_r != $past(gd_r) |-> gd_r == $past(gd_r) + 1'b1)
    else $error("global depth jumped");

endmodule
